// ----- hdl/ptta_pkg.sv -----
// Shared constants, register codes and the arctangent table for the position
// PID to thrust/attitude block. No dependencies.
package ptta_pkg;

  // integrator width in bits
  localparam int IW = 32;
  // shared multiplier operand width: wide enough for a gain times an integrator
  localparam int MW = (IW + 1 > 33) ? IW + 1 : 33;
  // force accumulator width before saturation
  localparam int AW = IW + 12;
  // CORDIC datapath width
  localparam int CW = 35;
  localparam int ZW = 19;

  // gravity, 9.8066 in units of 2^-16
  localparam logic [19:0] G_Q16 = 20'd642685;
  // floor(x/25) == (x * RECIP25) >> RECIP_SHIFT for x < 2^23
  localparam logic [23:0] RECIP25     = 24'd10737419;
  localparam int          RECIP_SHIFT = 28;
  localparam int          QW          = 18;

  localparam int CORDIC_STEPS = 17;

  localparam logic [1:0] REG_PROP  = 2'd0;
  localparam logic [1:0] REG_DERIV = 2'd1;
  localparam logic [1:0] REG_INTEG = 2'd2;
  localparam logic [1:0] REG_MASS  = 2'd3;

  // atan(2^-i) in units of 2^-16 rad
  function automatic logic [15:0] atan_entry(input logic [4:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ptta_isqrt.sv -----
// Bit-serial integer square root of a 64-bit radicand, two radicand bits per cycle.
// Depends on nothing beyond the clock and reset.
module ptta_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        run;
  logic [63:0] n;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n    <= radicand;
        r    <= 64'd0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt  <= 5'd0;
        run  <= 1'b1;
      end else if (run) begin
        if (n >= trial) begin
          n <= n - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/ptta_cordic.sv -----
// CORDIC vectoring unit: normalizes (x, y) by single-bit shifts, then runs the
// rotation steps and rounds the angle to Q2.13. Uses ptta_pkg.
module ptta_cordic import ptta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic                 done,
  output logic signed [15:0]   angle
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_DOWN = 3'd1;
  localparam logic [2:0] C_UP   = 3'd2;
  localparam logic [2:0] C_ROT  = 3'd3;
  localparam logic [2:0] C_FIN  = 3'd4;

  logic [2:0]           state;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [4:0]           i;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] mag;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] tab;
  logic signed [ZW-1:0] zr;

  always_comb begin
    ay  = y[CW-1] ? -y : y;
    mag = (x > ay) ? x : ay;
    dx  = y >>> i;
    dy  = x >>> i;
    tab = signed'(ZW'(atan_entry(i)));
    zr  = (z + ZW'(4)) >>> 3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            x     <= x_in;
            y     <= y_in;
            state <= C_DOWN;
          end
        end
        C_DOWN: begin
          // shrink until the larger magnitude is below 2^31
          if (mag[CW-2:31] != '0) begin
            x <= x >>> 1;
            y <= y >>> 1;
          end else begin
            state <= C_UP;
          end
        end
        C_UP: begin
          // grow until the larger magnitude reaches 2^30
          if (mag[CW-2:30] == '0) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            i     <= 5'd0;
            z     <= '0;
            state <= C_ROT;
          end
        end
        C_ROT: begin
          if (!y[CW-1]) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + tab;
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - tab;
          end
          i <= i + 5'd1;
          if (i == 5'(CORDIC_STEPS - 1)) state <= C_FIN;
        end
        C_FIN: begin
          // the table sum bounds the angle well inside 16 bits
          angle <= zr[15:0];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/position_pid_to_thrust_attitude_top.sv -----
// Position PID to thrust and roll/pitch, sequenced over one shared multiplier,
// a bit-serial square root and a CORDIC unit. Uses ptta_pkg, ptta_isqrt, ptta_cordic.
// The sequence runs two square roots and one or two CORDIC passes; a zero force vector
// skips them and finishes with the degenerate flag set. One word at a time: the next word
// is taken the cycle after the result register loads. Synchronous reset clears
// integrators and gains and sets the mass to 1 kg.
module position_pid_to_thrust_attitude_top import ptta_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic signed [15:0] pos_err_x,
  input  logic signed [15:0] pos_err_y,
  input  logic signed [15:0] pos_err_z,
  input  logic signed [15:0] vel_err_x,
  input  logic signed [15:0] vel_err_y,
  input  logic signed [15:0] vel_err_z,
  input  logic signed [15:0] acc_ref_x,
  input  logic signed [15:0] acc_ref_y,
  input  logic signed [15:0] acc_ref_z,
  input  logic               clear_integrators,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [23:0]        thrust,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic               degenerate
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_MG     = 5'd1;
  localparam logic [4:0] ST_M0     = 5'd2;
  localparam logic [4:0] ST_M1     = 5'd3;
  localparam logic [4:0] ST_M2     = 5'd4;
  localparam logic [4:0] ST_M3     = 5'd5;
  localparam logic [4:0] ST_M4     = 5'd6;
  localparam logic [4:0] ST_M5     = 5'd7;
  localparam logic [4:0] ST_H      = 5'd8;
  localparam logic [4:0] ST_SQ0    = 5'd9;
  localparam logic [4:0] ST_SQ1    = 5'd10;
  localparam logic [4:0] ST_SQ2    = 5'd11;
  localparam logic [4:0] ST_SQ3    = 5'd12;
  localparam logic [4:0] ST_CHK    = 5'd13;
  localparam logic [4:0] ST_THRW   = 5'd14;
  localparam logic [4:0] ST_RXW    = 5'd15;
  localparam logic [4:0] ST_ROLLW  = 5'd16;
  localparam logic [4:0] ST_PITW   = 5'd17;
  localparam logic [4:0] ST_DONE   = 5'd18;

  logic [4:0]             state;
  logic [1:0]             axis;
  logic [47:0]            prop_gains;
  logic [47:0]            deriv_gains;
  logic [47:0]            integ_gains;
  logic [15:0]            vehicle_mass;

  logic signed [15:0]     pe [3];
  logic signed [15:0]     ve [3];
  logic signed [15:0]     ac [3];
  logic signed [IW-1:0]   integ [3];
  logic signed [31:0]     f [3];
  logic signed [31:0]     mg;
  logic signed [31:0]     h;
  logic signed [AW-1:0]   acc;
  logic [63:0]            sxh;
  logic [63:0]            s;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] prod;

  logic [23:0]            thr_r;
  logic signed [15:0]     roll_r;
  logic signed [15:0]     pitch_r;
  logic                   degen_r;

  logic [15:0]            kp;
  logic [15:0]            kd;
  logic [15:0]            ki;
  logic signed [15:0]     pe_cur;
  logic                   pe_neg;
  logic [16:0]            pe_abs;
  logic [23:0]            mag_bias;
  logic [QW-1:0]          q;
  logic signed [IW:0]     isum;
  logic signed [IW-1:0]   inew;
  logic                   pitch_skip;

  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [63:0]            sqrt_rad;
  logic [31:0]            sqrt_root;
  logic                   cor_start;
  logic                   cor_done;
  logic signed [CW-1:0]   cor_x;
  logic signed [CW-1:0]   cor_y;
  logic signed [15:0]     cor_angle;

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic hi_zero;
    logic hi_ones;
    logic signed [31:0] res;
    hi_zero = (v[AW-1:31] == '0);
    hi_ones = &v[AW-1:31];
    if (hi_zero || hi_ones) res = v[31:0];
    else if (v[AW-1])       res = 32'sh8000_0000;
    else                    res = 32'sh7fff_ffff;
    return res;
  endfunction

  assign cmd_ready = (state == ST_IDLE);

  always_comb begin
    kp       = prop_gains[16*axis +: 16];
    kd       = deriv_gains[16*axis +: 16];
    ki       = integ_gains[16*axis +: 16];
    pe_cur   = pe[axis];
    pe_neg   = pe_cur[15];
    pe_abs   = pe_neg ? -17'(pe_cur) : 17'(pe_cur);
    mag_bias = {pe_abs, 7'd0} + 24'd12;
    q        = prod[RECIP_SHIFT +: QW];
    isum     = pe_neg ? (IW+1)'(integ[axis]) - signed'((IW+1)'(q))
                      : (IW+1)'(integ[axis]) + signed'((IW+1)'(q));
    // saturate the integrator on overflow
    if (isum[IW] != isum[IW-1])
      inew = isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    else
      inew = isum[IW-1:0];
    pitch_skip = (h == '0) && (f[0] == '0);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MG:  begin mul_a = MW'(vehicle_mass); mul_b = MW'(G_Q16);    end
      ST_M0:  begin mul_a = MW'(kp);           mul_b = MW'(pe_cur);   end
      ST_M1:  begin mul_a = MW'(kd);           mul_b = MW'(ve[axis]); end
      ST_M2:  begin mul_a = MW'(ki);           mul_b = MW'(integ[axis]); end
      ST_M3:  begin mul_a = MW'(vehicle_mass); mul_b = MW'(ac[axis]); end
      ST_M4:  begin mul_a = MW'(mag_bias);     mul_b = MW'(RECIP25);  end
      ST_SQ0: begin mul_a = MW'(f[0]);         mul_b = MW'(f[0]);     end
      ST_SQ1: begin mul_a = MW'(h);            mul_b = MW'(h);        end
      ST_SQ2: begin mul_a = MW'(f[1]);         mul_b = MW'(f[1]);     end
      default: begin mul_a = '0;               mul_b = '0;            end
    endcase
  end

  always_comb begin
    sqrt_start = ((state == ST_CHK) && (s != '0)) || ((state == ST_THRW) && sqrt_done);
    sqrt_rad   = (state == ST_CHK) ? s : sxh;
    cor_start  = ((state == ST_RXW) && sqrt_done) ||
                 ((state == ST_ROLLW) && cor_done && !pitch_skip);
    if (state == ST_RXW) begin
      cor_x = CW'(sqrt_root);
      cor_y = CW'(f[1]);
    end else begin
      cor_x = h[31] ? -CW'(h) : CW'(h);
      cor_y = h[31] ? CW'(f[0]) : -CW'(f[0]);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gains   <= '0;
      deriv_gains  <= '0;
      integ_gains  <= '0;
      vehicle_mass <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP:  prop_gains   <= cfg_data;
        REG_DERIV: deriv_gains  <= cfg_data;
        REG_INTEG: integ_gains  <= cfg_data;
        REG_MASS:  vehicle_mass <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 2'd0;
      res_valid <= 1'b0;
      integ[0]  <= '0;
      integ[1]  <= '0;
      integ[2]  <= '0;
    end else begin
      // the done state reloads the result register itself
      if (res_valid && res_ready && (state != ST_DONE)) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            pe[0] <= pos_err_x; pe[1] <= pos_err_y; pe[2] <= pos_err_z;
            ve[0] <= vel_err_x; ve[1] <= vel_err_y; ve[2] <= vel_err_z;
            ac[0] <= acc_ref_x; ac[1] <= acc_ref_y; ac[2] <= acc_ref_z;
            if (clear_integrators) begin
              integ[0] <= '0;
              integ[1] <= '0;
              integ[2] <= '0;
            end
            axis  <= 2'd0;
            state <= ST_MG;
          end
        end
        ST_MG: state <= ST_M0;
        ST_M0: begin
          if (axis == 2'd0) mg <= signed'(prod[39:8]);
          state <= ST_M1;
        end
        ST_M1: begin
          acc   <= -AW'(prod);
          state <= ST_M2;
        end
        ST_M2: begin
          acc   <= acc - AW'(prod);
          state <= ST_M3;
        end
        ST_M3: begin
          acc   <= acc - AW'(prod >>> 8);
          state <= ST_M4;
        end
        ST_M4: begin
          acc   <= acc + AW'(prod);
          state <= ST_M5;
        end
        ST_M5: begin
          f[axis]     <= sat32(acc);
          integ[axis] <= inew;
          if (axis == 2'd2) begin
            state <= ST_H;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_M0;
          end
        end
        ST_H: begin
          h     <= sat32(AW'(mg) - AW'(f[2]));
          state <= ST_SQ0;
        end
        ST_SQ0: state <= ST_SQ1;
        ST_SQ1: begin
          sxh   <= prod[63:0];
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          sxh   <= sxh + prod[63:0];
          state <= ST_SQ3;
        end
        ST_SQ3: begin
          s     <= sxh + prod[63:0];
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (s == '0) begin
            thr_r   <= '0;
            roll_r  <= '0;
            pitch_r <= '0;
            degen_r <= 1'b1;
            state   <= ST_DONE;
          end else begin
            degen_r <= 1'b0;
            state   <= ST_THRW;
          end
        end
        ST_THRW: begin
          // root of three squares stays below 2^32, so no clamp is reached
          if (sqrt_done) begin
            thr_r <= sqrt_root[31:8];
            state <= ST_RXW;
          end
        end
        ST_RXW: begin
          if (sqrt_done) state <= ST_ROLLW;
        end
        ST_ROLLW: begin
          if (cor_done) begin
            roll_r <= cor_angle;
            if (pitch_skip) begin
              pitch_r <= '0;
              state   <= ST_DONE;
            end else begin
              state <= ST_PITW;
            end
          end
        end
        ST_PITW: begin
          if (cor_done) begin
            pitch_r <= cor_angle;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!res_valid || res_ready) begin
            thrust      <= thr_r;
            roll_angle  <= roll_r;
            pitch_angle <= pitch_r;
            degenerate  <= degen_r;
            res_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ptta_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  ptta_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .done  (cor_done),
    .angle (cor_angle)
  );

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> state != ST_IDLE)
    else $error("accepted word did not start the sequencer");

  a_sqrt_done_expected: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == ST_THRW) || (state == ST_RXW))
    else $error("square root finished outside a wait state");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == ST_ROLLW) || (state == ST_PITW))
    else $error("cordic finished outside a wait state");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && degenerate |-> thrust == '0 && roll_angle == '0 && pitch_angle == '0)
    else $error("degenerate word carries nonzero outputs");

endmodule
